// ===== rtl/core/occupancy_grid_marker_top_assert.svh =====
// assertion macros for the occupancy grid marker
// expects clk and rst in the scope of each use
`ifndef OCCUPANCY_GRID_MARKER_TOP_ASSERT_SVH
`define OCCUPANCY_GRID_MARKER_TOP_ASSERT_SVH

// same-cycle implication
`define OGM_ASSERT_NOW(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// next-cycle implication
`define OGM_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== rtl/core/ogm_pkg.sv =====
// shared types and constants of the occupancy grid marker
// used by ogm_cell_mem, occupancy_grid_marker_top, the checker and the bench top
package ogm_pkg;

  localparam int unsigned GRID_WIDTH_DEF  = 256;
  localparam int unsigned GRID_HEIGHT_DEF = 256;

  localparam logic [15:0] CELL_SIZE_RESET = 16'd256;

  localparam logic [1:0] MODE_LIDAR  = 2'd0;
  localparam logic [1:0] MODE_ANCHOR = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  localparam logic [1:0] CELL_FREE   = 2'd0;
  localparam logic [1:0] CELL_HIT    = 2'd1;
  localparam logic [1:0] CELL_ANCHOR = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [23:0] offset_x;
    logic signed [23:0] offset_y;
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
    logic               anchor_visible;
  } in_t;

  typedef struct packed {
    logic        in_grid;
    logic [16:0] filled_cells;
    logic [15:0] known_anchors;
    logic [15:0] visible_anchors;
  } out_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clear;
  } mem_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_INDEX,
    ST_READ,
    ST_SWEEP,
    ST_OUT
  } state_t;

endpackage

// ===== rtl/core/occupancy_grid_marker_top.sv =====
// Occupancy grid marker: keeps a GRID_WIDTH x GRID_HEIGHT map of 2-bit cells in one
// synchronous memory and handles one request at a time. A lidar point or anchor mark
// passes from acceptance to result through the two per-axis floor dividers (25
// quotient bits, one per cycle, then a sign fix-up), the capture of the cell
// coordinates, the forming of the cell address with the memory read, the write-back
// of the cell with the occupied count update, and the load of the output register; a
// point off the grid skips the memory. The next request is taken the cycle after the
// result is loaded, so a new point is not taken before the last one's result is
// loaded. A clear, and reset itself, zero the memory one cell per cycle, during which
// in_stall stays high; a clear's result is loaded once its sweep ends.
// A result waits in the output register while the next request is taken in.
// Depends on ogm_pkg, ogm_floor_div, ogm_cell_mem and the assertion macro header.
`include "occupancy_grid_marker_top_assert.svh"

module occupancy_grid_marker_top #(
  parameter int unsigned GRID_WIDTH  = ogm_pkg::GRID_WIDTH_DEF,
  parameter int unsigned GRID_HEIGHT = ogm_pkg::GRID_HEIGHT_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [15:0]   cfg_wdata,
  input  logic          in_valid,
  output logic          in_stall,
  input  ogm_pkg::in_t  in_req,
  output logic          out_valid,
  input  logic          out_stall,
  output ogm_pkg::out_t out_rsp
);

  localparam int unsigned CELL_TOTAL = GRID_WIDTH * GRID_HEIGHT;
  localparam int unsigned ADDR_W     = $clog2(CELL_TOTAL);
  localparam int unsigned XW         = $clog2(GRID_WIDTH);
  localparam int unsigned YW         = $clog2(GRID_HEIGHT);
  localparam int unsigned CNT_W      = $clog2(CELL_TOTAL + 1);
  localparam int unsigned HALF_X     = GRID_WIDTH / 2;
  localparam int unsigned HALF_Y     = GRID_HEIGHT / 2;

  ogm_pkg::state_t   state;
  ogm_pkg::state_t   state_next;
  ogm_pkg::in_t      item;
  logic [15:0]       cell_size;
  logic              hit;
  logic signed [26:0] gx;
  logic signed [26:0] gy;
  logic [ADDR_W-1:0] cell_addr;
  logic [CNT_W-1:0]  occ;
  logic [15:0]       known;
  logic [15:0]       visible;

  logic              accept;
  logic              div_start;
  logic signed [24:0] wx;
  logic signed [24:0] wy;
  logic [15:0]       divisor;
  logic              x_done;
  logic              y_done;
  logic signed [25:0] qx;
  logic signed [25:0] qy;
  logic              in_range;
  logic [ADDR_W-1:0] addr_calc;
  logic [ADDR_W-1:0] mem_addr;
  logic [1:0]        wr_data;
  logic [1:0]        rd_data;
  logic              mem_busy;
  ogm_pkg::mem_req_t mem_req;
  logic              out_load;
  logic [31:0]       occ_wide;

  ogm_floor_div u_div_x (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (wx),
    .divisor  (divisor),
    .done     (x_done),
    .quotient (qx)
  );

  ogm_floor_div u_div_y (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (wy),
    .divisor  (divisor),
    .done     (y_done),
    .quotient (qy)
  );

  ogm_cell_mem #(
    .DEPTH (CELL_TOTAL)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .req     (mem_req),
    .addr    (mem_addr),
    .wr_data (wr_data),
    .rd_data (rd_data),
    .busy    (mem_busy)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ogm_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_req.mode == ogm_pkg::MODE_LIDAR || in_req.mode == ogm_pkg::MODE_ANCHOR) begin
            state_next = ogm_pkg::ST_DIV;
          end else if (in_req.mode == ogm_pkg::MODE_CLEAR) begin
            state_next = ogm_pkg::ST_SWEEP;
          end else begin
            state_next = ogm_pkg::ST_OUT;
          end
        end
      end
      ogm_pkg::ST_DIV: begin
        if (x_done) begin
          state_next = ogm_pkg::ST_INDEX;
        end
      end
      ogm_pkg::ST_INDEX: begin
        state_next = in_range ? ogm_pkg::ST_READ : ogm_pkg::ST_OUT;
      end
      ogm_pkg::ST_READ: begin
        state_next = ogm_pkg::ST_OUT;
      end
      ogm_pkg::ST_SWEEP: begin
        if (!mem_busy) begin
          state_next = ogm_pkg::ST_OUT;
        end
      end
      ogm_pkg::ST_OUT: begin
        if (out_load) begin
          state_next = ogm_pkg::ST_IDLE;
        end
      end
      default: state_next = ogm_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath controls
  always_comb begin
    in_stall  = !(state == ogm_pkg::ST_IDLE && !mem_busy);
    accept    = in_valid && !in_stall;
    div_start = accept && (in_req.mode == ogm_pkg::MODE_LIDAR ||
                           in_req.mode == ogm_pkg::MODE_ANCHOR);
    // lidar points are relative to the vehicle, anchors are absolute
    if (in_req.mode == ogm_pkg::MODE_LIDAR) begin
      wx = {in_req.offset_x[23], in_req.offset_x} + {in_req.point_x[23], in_req.point_x};
      wy = {in_req.offset_y[23], in_req.offset_y} + {in_req.point_y[23], in_req.point_y};
    end else begin
      wx = {in_req.point_x[23], in_req.point_x};
      wy = {in_req.point_y[23], in_req.point_y};
    end
    divisor   = (cell_size == 16'd0) ? 16'd1 : cell_size;
    in_range  = !gx[26] && !gy[26] &&
                ($unsigned(gx) < 27'(GRID_WIDTH)) && ($unsigned(gy) < 27'(GRID_HEIGHT));
    addr_calc = ADDR_W'(ADDR_W'(gy[YW-1:0]) * ADDR_W'(GRID_WIDTH)) + ADDR_W'(gx[XW-1:0]);
    mem_req.clear = accept && in_req.mode == ogm_pkg::MODE_CLEAR;
    mem_req.rd_en = (state == ogm_pkg::ST_INDEX) && in_range;
    mem_req.wr_en = (state == ogm_pkg::ST_READ);
    mem_addr  = (state == ogm_pkg::ST_READ) ? cell_addr : addr_calc;
    wr_data   = (item.mode == ogm_pkg::MODE_ANCHOR) ? ogm_pkg::CELL_ANCHOR : ogm_pkg::CELL_HIT;
    out_load  = (state == ogm_pkg::ST_OUT) && (!out_valid || !out_stall);
    occ_wide  = 32'(occ);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ogm_pkg::ST_IDLE;
      cell_size <= ogm_pkg::CELL_SIZE_RESET;
      occ       <= '0;
      known     <= '0;
      visible   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        cell_size <= cfg_wdata;
      end
      if (accept && in_req.mode == ogm_pkg::MODE_CLEAR) begin
        occ     <= '0;
        known   <= '0;
        visible <= '0;
      end else if (accept && in_req.mode == ogm_pkg::MODE_ANCHOR) begin
        if (known != 16'hFFFF) begin
          known <= known + 16'd1;
        end
        if (in_req.anchor_visible && visible != 16'hFFFF) begin
          visible <= visible + 16'd1;
        end
      end else if (state == ogm_pkg::ST_READ && rd_data == ogm_pkg::CELL_FREE) begin
        occ <= occ + 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_req;
      hit  <= 1'b0;
    end else if (state == ogm_pkg::ST_READ) begin
      hit <= 1'b1;
    end
    if (x_done) begin
      gx <= {qx[25], qx} + 27'(HALF_X);
      gy <= {qy[25], qy} + 27'(HALF_Y);
    end
    if (state == ogm_pkg::ST_INDEX) begin
      cell_addr <= addr_calc;
    end
    if (out_load) begin
      out_rsp.in_grid         <= hit;
      out_rsp.filled_cells    <= occ_wide[16:0];
      out_rsp.known_anchors   <= known;
      out_rsp.visible_anchors <= visible;
    end
  end

  `OGM_ASSERT_NOW(a_div_lockstep, x_done, y_done, "axis dividers out of step")
  `OGM_ASSERT_NEXT(a_clear_sweeps, accept && in_req.mode == ogm_pkg::MODE_CLEAR, mem_busy,
                   "clear request did not start the sweep")
  `OGM_ASSERT_NOW(a_occ_bound, 1'b1, occ <= CNT_W'(CELL_TOTAL), "occupied count past grid size")
  `OGM_ASSERT_NOW(a_write_after_read, mem_req.wr_en, $past(mem_req.rd_en),
                  "cell write without a preceding read")

endmodule

// ===== rtl/core/ogm_floor_div.sv =====
// radix-2 restoring divider giving floor(dividend / divisor) for a positive divisor
// one quotient bit per cycle, then a sign fix-up; no package use
module ogm_floor_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [24:0] dividend,
  input  logic [15:0]        divisor,
  output logic               done,
  output logic signed [25:0] quotient
);

  localparam int unsigned STEPS = 25;

  logic        busy;
  logic [4:0]  cnt;
  logic [15:0] rem;
  logic [24:0] quo;
  logic        neg;
  logic [15:0] dvs;

  logic [24:0] mag;
  logic [16:0] trial;
  logic [16:0] diff;
  logic        ge;
  logic [15:0] rem_next;
  logic [25:0] q_ext;
  logic [25:0] q_fix;

  always_comb begin
    mag      = dividend[24] ? (~dividend + 25'd1) : dividend;
    trial    = {rem, quo[24]};
    diff     = trial - {1'b0, dvs};
    ge       = (trial >= {1'b0, dvs});
    rem_next = ge ? diff[15:0] : trial[15:0];
    q_ext    = {1'b0, quo};
    // negative: -q - 1 when a remainder is left, else -q
    if (neg) begin
      q_fix = (rem != 16'd0) ? ~q_ext : (~q_ext + 26'd1);
    end else begin
      q_fix = q_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == 5'(STEPS)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= mag;
      rem <= '0;
      neg <= dividend[24];
      dvs <= divisor;
    end else if (busy) begin
      if (cnt == 5'(STEPS)) begin
        quotient <= $signed(q_fix);
      end else begin
        rem <= rem_next;
        quo <= {quo[23:0], ge};
      end
    end
  end

endmodule

// ===== rtl/core/ogm_cell_mem.sv =====
// cell store: one synchronous 2-bit memory with a zeroing sweep
// depends on ogm_pkg for the request struct and cell codes
module ogm_cell_mem #(
  parameter int unsigned DEPTH = ogm_pkg::GRID_WIDTH_DEF * ogm_pkg::GRID_HEIGHT_DEF,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rst,
  input  ogm_pkg::mem_req_t req,
  input  logic [ADDR_W-1:0] addr,
  input  logic [1:0]        wr_data,
  output logic [1:0]        rd_data,
  output logic              busy
);

  logic [1:0]        mem [DEPTH];
  logic [ADDR_W-1:0] sweep_cnt;

  // sweep runs after reset and after a clear request
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b1;
      sweep_cnt <= '0;
    end else if (req.clear) begin
      busy      <= 1'b1;
      sweep_cnt <= '0;
    end else if (busy) begin
      if (sweep_cnt == ADDR_W'(DEPTH - 1)) begin
        busy <= 1'b0;
      end else begin
        sweep_cnt <= sweep_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[sweep_cnt] <= ogm_pkg::CELL_FREE;
    end else if (req.wr_en) begin
      mem[addr] <= wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[addr];
    end
  end

endmodule

// ===== bench/occupancy_grid_marker_checker.sv =====
`timescale 1ns / 100ps
// result checker for the occupancy grid marker: follows the config, request and result
// channels, keeps its own grid and counters, and compares each result in order
// depends on ogm_pkg
module occupancy_grid_marker_checker #(
  parameter int unsigned GRID_WIDTH  = ogm_pkg::GRID_WIDTH_DEF,
  parameter int unsigned GRID_HEIGHT = ogm_pkg::GRID_HEIGHT_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [15:0]   cfg_wdata,
  input  logic          in_valid,
  input  logic          in_stall,
  input  ogm_pkg::in_t  in_req,
  input  logic          out_valid,
  input  logic          out_stall,
  input  ogm_pkg::out_t out_rsp,
  output int unsigned   mismatch_count,
  output int unsigned   pending
);

  localparam logic [15:0] COUNT_MAX    = 16'hFFFF;
  localparam int unsigned REPORT_LIMIT = 10;

  logic [1:0]    grid_cells [int unsigned];
  logic [16:0]   occupied_total;
  logic [15:0]   known_total;
  logic [15:0]   visible_total;
  logic [15:0]   cell_size;
  ogm_pkg::out_t marking_q [$];
  int unsigned   fail_total = 0;
  int unsigned   waiting = 0;

  assign mismatch_count = fail_total;
  assign pending = waiting;

  // floor division toward minus infinity, then shift to the grid center
  function automatic longint grid_index(longint coord, int unsigned span);
    longint step;
    longint q;
    step = (cell_size == 16'd0) ? 64'sd1 : longint'(cell_size);
    q = coord / step;
    if ((coord % step) != 0 && coord < 0) q = q - 1;
    return q + longint'(span / 2);
  endfunction

  function automatic logic place_mark(longint wx, longint wy, logic [1:0] code);
    longint gx;
    longint gy;
    int unsigned idx;
    gx = grid_index(wx, GRID_WIDTH);
    gy = grid_index(wy, GRID_HEIGHT);
    if (gx < 0 || gx >= longint'(GRID_WIDTH) || gy < 0 || gy >= longint'(GRID_HEIGHT))
      return 1'b0;
    idx = 32'(gy * GRID_WIDTH + gx);
    // overwriting a non-free cell leaves the count alone
    if (!grid_cells.exists(idx) || grid_cells[idx] == ogm_pkg::CELL_FREE) occupied_total++;
    grid_cells[idx] = code;
    return 1'b1;
  endfunction

  function automatic ogm_pkg::out_t predict_marking(ogm_pkg::in_t req);
    ogm_pkg::out_t res;
    logic hit;
    hit = 1'b0;
    case (req.mode)
      ogm_pkg::MODE_LIDAR: begin
        hit = place_mark(longint'(signed'(req.offset_x)) + longint'(signed'(req.point_x)),
                         longint'(signed'(req.offset_y)) + longint'(signed'(req.point_y)),
                         ogm_pkg::CELL_HIT);
      end
      ogm_pkg::MODE_ANCHOR: begin
        // counted even when the anchor lies off the grid
        hit = place_mark(longint'(signed'(req.point_x)), longint'(signed'(req.point_y)),
                         ogm_pkg::CELL_ANCHOR);
        if (known_total != COUNT_MAX) known_total++;
        if (req.anchor_visible && visible_total != COUNT_MAX) visible_total++;
      end
      ogm_pkg::MODE_CLEAR: begin
        grid_cells.delete();
        occupied_total = '0;
        known_total = '0;
        visible_total = '0;
      end
      default: ;
    endcase
    res.in_grid = hit;
    res.filled_cells = occupied_total;
    res.known_anchors = known_total;
    res.visible_anchors = visible_total;
    return res;
  endfunction

  task automatic note_failure(string detail);
    fail_total++;
    if (fail_total <= REPORT_LIMIT) $display("%0t: %s", $time, detail);
  endtask

  always @(posedge clk) begin : watch
    ogm_pkg::out_t want;
    if (rst) begin
      grid_cells.delete();
      occupied_total = '0;
      known_total = '0;
      visible_total = '0;
      cell_size = ogm_pkg::CELL_SIZE_RESET;
      marking_q.delete();
    end else begin
      // a request taken at this edge still sees the old cell size
      if (in_valid && !in_stall) marking_q.push_back(predict_marking(in_req));
      if (cfg_we) cell_size = cfg_wdata;
      if (out_valid && !out_stall) begin
        if (marking_q.size() == 0) begin
          note_failure($sformatf("result with no request waiting: in_grid=%0d occupied=%0d %s",
                                 out_rsp.in_grid, out_rsp.filled_cells,
                                 $sformatf("known=%0d visible=%0d",
                                           out_rsp.known_anchors, out_rsp.visible_anchors)));
        end else begin
          want = marking_q.pop_front();
          if (out_rsp.in_grid !== want.in_grid ||
              out_rsp.filled_cells !== want.filled_cells ||
              out_rsp.known_anchors !== want.known_anchors ||
              out_rsp.visible_anchors !== want.visible_anchors) begin
            note_failure($sformatf(
              "result mismatch: expected in_grid=%0d occupied=%0d known=%0d visible=%0d, %s",
              want.in_grid, want.filled_cells, want.known_anchors, want.visible_anchors,
              $sformatf("got in_grid=%0d occupied=%0d known=%0d visible=%0d",
                        out_rsp.in_grid, out_rsp.filled_cells,
                        out_rsp.known_anchors, out_rsp.visible_anchors)));
          end
        end
      end
    end
    waiting = marking_q.size();
  end

endmodule

// ===== bench/tb_occupancy_grid_marker_top.sv =====
`timescale 1ns / 100ps
// bench top for the occupancy grid marker: clock, reset, request and result drivers,
// directed then random requests over several cell sizes, verdict from the checker
// depends on ogm_pkg, occupancy_grid_marker_top and occupancy_grid_marker_checker
module tb_occupancy_grid_marker_top;

  localparam logic [1:0]  MODE_SPARE     = 2'd3;
  localparam int unsigned PHASE_COUNT    = 6;
  localparam int unsigned PHASE_ITEMS    = 265;
  localparam int unsigned SQUEEZE_CYCLES = 400;
  localparam int unsigned MAX_CLEARS     = 4;
  localparam int unsigned POOL_SIZE      = 16;
  localparam longint      COORD_MIN      = -64'sd8388608;
  localparam longint      COORD_MAX      = 64'sd8388607;

  logic          clk;
  logic          rst;
  logic          cfg_we;
  logic [15:0]   cfg_wdata;
  logic          in_valid;
  logic          in_stall;
  ogm_pkg::in_t  in_req;
  logic          out_valid;
  logic          out_stall;
  ogm_pkg::out_t out_rsp;
  int unsigned   mismatch_count;
  int unsigned   pending;

  logic        in_idle_en;
  logic        out_idle_en;
  logic        squeeze;
  logic [15:0] cur_cell_size;
  int unsigned clears_left;
  int          pool_x [POOL_SIZE];
  int          pool_y [POOL_SIZE];

  occupancy_grid_marker_top i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_req(in_req),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_rsp(out_rsp)
  );

  occupancy_grid_marker_checker i_checker (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_req(in_req),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_rsp(out_rsp),
    .mismatch_count(mismatch_count),
    .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("Mismatches found");
    $finish;
  end

  // result side: random stalls, plus one long hold-off to back the block up
  initial begin : result_side
    logic squeezed;
    squeezed = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(negedge clk);
      if (squeeze && !squeezed) begin
        squeezed = 1'b1;
        out_stall <= 1'b1;
        repeat (SQUEEZE_CYCLES) @(negedge clk);
      end
      out_stall <= out_idle_en && ($urandom_range(99, 0) < 10);
    end
  end

  function automatic logic signed [23:0] clamp24(longint v);
    if (v > COORD_MAX) return 24'sh7FFFFF;
    if (v < COORD_MIN) return 24'sh800000;
    return v[23:0];
  endfunction

  function automatic longint rand24();
    logic [23:0] raw;
    raw = 24'($urandom);
    return longint'($signed(raw));
  endfunction

  // world coordinate somewhere inside grid cell g along an axis of the given span
  function automatic longint cell_world(int g, int unsigned span);
    longint step;
    step = (cur_cell_size == 16'd0) ? 64'sd1 : longint'(cur_cell_size);
    return (longint'(g) - longint'(span / 2)) * step +
           longint'($urandom_range(32'(step - 64'sd1), 0));
  endfunction

  function automatic ogm_pkg::in_t make_req(logic [1:0] mode, longint ox, longint oy,
                                            longint px, longint py, logic vis);
    ogm_pkg::in_t r;
    r.mode = mode;
    r.offset_x = clamp24(ox);
    r.offset_y = clamp24(oy);
    r.point_x = clamp24(px);
    r.point_y = clamp24(py);
    r.anchor_visible = vis;
    return r;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic push_request(ogm_pkg::in_t req);
    if (in_idle_en && $urandom_range(99, 0) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_requests();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_cell_size(logic [15:0] size);
    cfg_we <= 1'b1;
    cfg_wdata <= size;
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_cell_size = size;
  endtask

  task automatic random_phase(int unsigned count);
    ogm_pkg::in_t req;
    int unsigned roll;
    int unsigned slot;
    int gx;
    int gy;
    longint wx;
    longint wy;
    longint ox;
    longint oy;
    for (int k = 0; k < POOL_SIZE; k++) begin
      pool_x[k] = $urandom_range(ogm_pkg::GRID_WIDTH_DEF - 1, 0);
      pool_y[k] = $urandom_range(ogm_pkg::GRID_HEIGHT_DEF - 1, 0);
    end
    for (int unsigned n = 0; n < count; n++) begin
      roll = $urandom_range(999, 0);
      // half the targets revisit a small set of cells so hits land on marked cells
      if ($urandom_range(1, 0)) begin
        slot = $urandom_range(POOL_SIZE - 1, 0);
        gx = pool_x[slot];
        gy = pool_y[slot];
      end else begin
        gx = int'($urandom_range(ogm_pkg::GRID_WIDTH_DEF, 0)) - 1;
        gy = int'($urandom_range(ogm_pkg::GRID_HEIGHT_DEF, 0)) - 1;
      end
      wx = cell_world(gx, ogm_pkg::GRID_WIDTH_DEF);
      wy = cell_world(gy, ogm_pkg::GRID_HEIGHT_DEF);
      if (roll < 480) begin
        // split the target between vehicle offset and relative point
        ox = rand24();
        oy = rand24();
        if (wx - ox < COORD_MIN || wx - ox > COORD_MAX) ox = wx / 2;
        if (wy - oy < COORD_MIN || wy - oy > COORD_MAX) oy = wy / 2;
        req = make_req(ogm_pkg::MODE_LIDAR, ox, oy, wx - ox, wy - oy,
                       1'($urandom_range(1, 0)));
      end else if (roll < 730) begin
        req = make_req(ogm_pkg::MODE_ANCHOR, rand24(), rand24(), wx, wy,
                       1'($urandom_range(1, 0)));
      end else if (roll < 930) begin
        req = make_req(2'($urandom_range(1, 0)), rand24(), rand24(), rand24(), rand24(),
                       1'($urandom_range(1, 0)));
      end else if (roll < 997 || clears_left == 0) begin
        req = make_req(MODE_SPARE, rand24(), rand24(), rand24(), rand24(),
                       1'($urandom_range(1, 0)));
      end else begin
        clears_left--;
        req = make_req(ogm_pkg::MODE_CLEAR, rand24(), rand24(), rand24(), rand24(),
                       1'($urandom_range(1, 0)));
      end
      push_request(req);
    end
  endtask

  initial begin : stimulus
    logic [15:0] phase_size [PHASE_COUNT];
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_req <= '0;
    in_idle_en = 1'b1;
    out_idle_en = 1'b1;
    squeeze = 1'b0;
    cur_cell_size = ogm_pkg::CELL_SIZE_RESET;
    clears_left = MAX_CLEARS;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part at the reset cell size of one meter
    push_request(make_req(ogm_pkg::MODE_LIDAR, 0, 0, 0, 0, 1'b0));
    push_request(make_req(ogm_pkg::MODE_LIDAR, 0, 0, 0, 0, 1'b1));
    push_request(make_req(ogm_pkg::MODE_ANCHOR, 0, 0, 1000, -1000, 1'b1));
    // lidar over the anchor cell
    push_request(make_req(ogm_pkg::MODE_LIDAR, 500, -500, 500, -500, 1'b0));
    push_request(make_req(ogm_pkg::MODE_ANCHOR, 0, 0, -32768, 32767, 1'b0));
    // anchors off the grid still count
    push_request(make_req(ogm_pkg::MODE_ANCHOR, 0, 0, 8388607, 8388607, 1'b1));
    push_request(make_req(ogm_pkg::MODE_ANCHOR, -1, -1, -8388608, -8388608, 1'b0));
    push_request(make_req(ogm_pkg::MODE_LIDAR, 8388607, 8388607, 8388607, 8388607, 1'b1));
    push_request(make_req(ogm_pkg::MODE_LIDAR, -8388608, -8388608, -8388608, -8388608,
                          1'b0));
    push_request(make_req(ogm_pkg::MODE_LIDAR, 8388607, -8388608, -8388608, 8388607, 1'b0));
    push_request(make_req(ogm_pkg::MODE_LIDAR, -32769, 0, 0, 0, 1'b0));
    push_request(make_req(ogm_pkg::MODE_LIDAR, 32767, 0, 1, 0, 1'b0));
    push_request(make_req(ogm_pkg::MODE_LIDAR, 0, 32767, 0, 0, 1'b0));
    push_request(make_req(ogm_pkg::MODE_LIDAR, 0, -32768, 0, -1, 1'b0));
    push_request(make_req(ogm_pkg::MODE_LIDAR, -1, 0, 0, -256, 1'b0));
    push_request(make_req(MODE_SPARE, 8388607, -8388608, 8388607, -8388608, 1'b1));
    push_request(make_req(ogm_pkg::MODE_CLEAR, -1, -1, -1, -1, 1'b1));
    push_request(make_req(ogm_pkg::MODE_LIDAR, 0, 0, 0, 0, 1'b0));
    push_request(make_req(ogm_pkg::MODE_ANCHOR, 0, 0, -300, 300, 1'b1));

    phase_size[0] = 16'd1;
    phase_size[1] = 16'hFFFF;
    phase_size[2] = 16'd0;
    phase_size[3] = 16'($urandom_range(65534, 2));
    phase_size[4] = ogm_pkg::CELL_SIZE_RESET;
    phase_size[5] = 16'($urandom_range(64, 2));
    for (int p = 0; p < PHASE_COUNT; p++) begin
      drain_requests();
      write_cell_size(phase_size[p]);
      // one phase runs with no gaps on either side
      in_idle_en = (p != 4);
      out_idle_en = (p != 4);
      if (p == 3) squeeze = 1'b1;
      random_phase(PHASE_ITEMS);
    end
    drain_requests();
    repeat (100) @(negedge clk);

    if (mismatch_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/ogm_pkg.sv
rtl/core/ogm_floor_div.sv
rtl/core/ogm_cell_mem.sv
rtl/core/occupancy_grid_marker_top.sv
bench/occupancy_grid_marker_checker.sv
bench/tb_occupancy_grid_marker_top.sv
